@@ design/voice_hysteresis_segmenter_defines.svh @@
// Assertion shorthands shared by the segmenter RTL.
`ifndef VOICE_HYSTERESIS_SEGMENTER_DEFINES_SVH
`define VOICE_HYSTERESIS_SEGMENTER_DEFINES_SVH

// Invariant checked at every clock edge out of reset.
`define VHS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define VHS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/vhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vhs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ENERGY_W   = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int CAP_W      = 9;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOICE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH     = 3'd4;

    localparam logic [7:0]          RST_MIN_VOICE  = 8'd3;
    localparam logic [7:0]          RST_HOLD       = 8'd8;
    localparam logic [5:0]          RST_END_SIL    = 6'd12;
    localparam logic [ENERGY_W-1:0] RST_THRESH     = 16'd655;

    localparam logic [ENERGY_W-1:0] THRESH_FLOOR   = 16'd7;
    localparam logic [5:0]          END_SIL_MIN    = 6'd3;
    localparam logic [5:0]          END_SIL_MAX    = 6'd50;
    localparam logic [15:0]         NOISE_TRACK_N  = 16'd50;
    localparam logic [15:0]         NOISE_GATE_N   = 16'd10;
    localparam int                  END_MIN_TOTAL  = 10;
    localparam int                  END_MIN_RECENT = 2;

endpackage

`default_nettype wire

@@ design/vhs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vhs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 150
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/voice_hysteresis_segmenter.sv @@
// Channel | Dir | Handshake                 | Payload
// s       | in  | i_s_tvalid / o_s_tready   | tuser: candidate_voice; tdata: frame_energy, end_ack
// m       | out | o_m_tvalid / i_m_tready   | tuser: voice_active; tdata: speech_end, threshold
// cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A frame runs ST_PRE, ST_VOICE, ST_TRIM, ST_WRITE, ST_FIN if the noise mean does not update
// and no end check runs; a noise update adds ST_MUL to ST_UPD (16x16 multiply, then a 32-step
// restoring divider); an end check reads one bit per cycle from the RAM read port, then decides.
// Reset is synchronous; the history RAM needs no clearing, its fill count starts at zero.
// Input and register writes are taken only while idle; a register write wins over a beat.
// A waiting result does not block input; the sequencer only waits at its last step for o_m.
`timescale 1ns / 1ps
`default_nettype none
`include "voice_hysteresis_segmenter_defines.svh"

module voice_hysteresis_segmenter
    import vhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 150
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,   // [15:0] frame_energy, [16] end_ack
    input  wire logic                  i_s_tuser,   // [0] candidate_voice
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [M_TDATA_W-1:0]  o_m_tdata,   // [0] speech_end, [16:1] adapted_threshold
    output logic                       o_m_tuser,   // [0] voice_active
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int LEN_W   = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_MUL, ST_SUM, ST_DIV, ST_UPD, ST_VOICE,
        ST_TRIM, ST_WRITE, ST_WALK, ST_DECIDE, ST_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0] r_min_voice;
    logic [7:0] r_hold;
    logic [5:0] r_end_sil;
    logic       r_adapt;

    // frame in work
    logic                r_cand;
    logic [ENERGY_W-1:0] r_energy;
    logic                r_ack;

    // segmenter state
    logic [7:0]          r_voice_run;
    logic [7:0]          r_sil_run;
    logic                r_voice_state;
    logic [15:0]         r_noise_mean;
    logic [15:0]         r_noise_frames;
    logic [ENERGY_W-1:0] r_energy_limit;
    logic [7:0]          r_end_run;
    logic                r_end_pend;
    logic [HIST_AW-1:0]  r_head;
    logic [LEN_W-1:0]    r_hist_len;

    // multiply / divide datapath of the noise update
    logic [31:0] r_prod;
    logic [31:0] r_dvd;
    logic [15:0] r_rem;
    logic [4:0]  r_div_cnt;

    // history walk
    logic [LEN_W-1:0] r_walk_idx;
    logic             r_rd_valid;
    logic [LEN_W-1:0] r_rd_pos;
    logic [LEN_W-1:0] r_total;
    logic [LEN_W-1:0] r_recent;

    // output register
    logic                r_m_valid;
    logic                r_out_voice;
    logic                r_out_end;
    logic [ENERGY_W-1:0] r_out_thr;

    logic [5:0]          need;
    logic [7:0]          need3;
    logic [LEN_W-1:0]    cap;
    logic [LEN_W-1:0]    trim_drop;
    logic [16:0]         rem_sh;
    logic                rem_ge;
    logic [16:0]         rem_sub;
    logic [15:0]         q_sat;
    logic [16:0]         q_dbl;
    logic [15:0]         lim_new;
    logic [7:0]          minv;
    logic [7:0]          hold;
    logic [7:0]          n_voice_run_inc;
    logic [7:0]          n_sil_run_inc;
    logic [7:0]          n_end_run_inc;
    logic [15:0]         n_noise_frames;
    logic [17:0]         noise3;
    logic                ram_we;
    logic                ram_re;
    logic [HIST_AW-1:0]  ram_waddr;
    logic [HIST_AW-1:0]  ram_raddr;
    logic                ram_rdata;

    function automatic logic [HIST_AW-1:0] hist_wrap(input logic [HIST_AW-1:0] base,
                                                     input logic [LEN_W-1:0]   off);
        logic [LEN_W:0] sum;
        sum = (LEN_W+1)'(base) + (LEN_W+1)'(off);
        if (sum >= (LEN_W+1)'(HISTORY_DEPTH)) begin
            sum = sum - (LEN_W+1)'(HISTORY_DEPTH);
        end
        return sum[HIST_AW-1:0];
    endfunction

    always_comb begin
        if (r_end_sil < END_SIL_MIN) begin
            need = END_SIL_MIN;
        end else if (r_end_sil > END_SIL_MAX) begin
            need = END_SIL_MAX;
        end else begin
            need = r_end_sil;
        end
        need3 = {2'b00, need} + {1'b0, need, 1'b0};
        if ({1'b0, need3} > CAP_W'(HISTORY_DEPTH)) begin
            cap = LEN_W'(HISTORY_DEPTH);
        end else begin
            cap = LEN_W'(need3);
        end
        trim_drop = r_hist_len - cap + LEN_W'(1);

        // one restoring divide step
        rem_sh  = {r_rem, r_dvd[31]};
        rem_ge  = rem_sh >= {1'b0, r_noise_frames};
        rem_sub = rem_sh - {1'b0, r_noise_frames};

        q_sat   = (|r_dvd[31:16]) ? 16'hFFFF : r_dvd[15:0];
        q_dbl   = {q_sat, 1'b0};
        if (q_dbl[16]) begin
            lim_new = 16'hFFFF;
        end else if (q_dbl[15:0] < THRESH_FLOOR) begin
            lim_new = THRESH_FLOOR;
        end else begin
            lim_new = q_dbl[15:0];
        end

        minv = (r_min_voice == 8'd0) ? 8'd1 : r_min_voice;
        hold = (r_hold == 8'd0) ? 8'd1 : r_hold;
        n_voice_run_inc = (r_voice_run == 8'hFF) ? r_voice_run : r_voice_run + 8'd1;
        n_sil_run_inc   = (r_sil_run == 8'hFF) ? r_sil_run : r_sil_run + 8'd1;
        n_end_run_inc   = (r_end_run == 8'hFF) ? r_end_run : r_end_run + 8'd1;
        n_noise_frames  = (r_noise_frames == 16'hFFFF) ? r_noise_frames
                                                       : r_noise_frames + 16'd1;
        noise3 = {2'b00, r_noise_mean} + {1'b0, r_noise_mean, 1'b0};

        ram_we    = (r_state == ST_WRITE);
        ram_waddr = hist_wrap(r_head, r_hist_len);
        ram_re    = (r_state == ST_WALK) && (r_walk_idx < r_hist_len);
        ram_raddr = hist_wrap(r_head, r_walk_idx);
    end

    vhs_ram #(
        .WIDTH (1),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (~r_voice_state),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_min_voice    <= RST_MIN_VOICE;
            r_hold         <= RST_HOLD;
            r_end_sil      <= RST_END_SIL;
            r_adapt        <= 1'b0;
            r_voice_run    <= 8'd0;
            r_sil_run      <= 8'd0;
            r_voice_state  <= 1'b0;
            r_noise_mean   <= 16'd0;
            r_noise_frames <= 16'd0;
            r_energy_limit <= RST_THRESH;
            r_end_run      <= 8'd0;
            r_end_pend     <= 1'b0;
            r_head         <= '0;
            r_hist_len     <= '0;
            r_rd_valid     <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            // in ST_FIN a taken beat is replaced by the new result below
            if (r_m_valid && i_m_tready && (r_state != ST_FIN)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid && !i_cfg_valid) begin
                        r_cand   <= i_s_tuser;
                        r_energy <= i_s_tdata[ENERGY_W-1:0];
                        r_ack    <= i_s_tdata[ENERGY_W];
                        r_state  <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    if (r_ack && r_end_pend) begin
                        r_end_pend <= 1'b0;
                        r_end_run  <= 8'd0;
                        r_hist_len <= '0;
                    end
                    if (r_adapt && (r_energy < r_energy_limit)) begin
                        r_noise_frames <= n_noise_frames;
                        r_state        <= ST_MUL;
                    end else begin
                        r_state <= ST_VOICE;
                    end
                end
                ST_MUL: begin
                    r_prod  <= 32'(r_noise_mean) * 32'(r_noise_frames - 16'd1);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    // mean * (n-1) + e + n/2, then divide by n (round half up)
                    r_dvd     <= r_prod + 32'(r_energy) + 32'(r_noise_frames[15:1]);
                    r_rem     <= 16'd0;
                    r_div_cnt <= 5'd0;
                    r_state   <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem     <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
                    r_dvd     <= {r_dvd[30:0], rem_ge};
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd31) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_noise_mean <= q_sat;
                    if (r_noise_frames > NOISE_TRACK_N) begin
                        r_energy_limit <= lim_new;
                    end
                    r_state <= ST_VOICE;
                end
                ST_VOICE: begin
                    if (r_cand) begin
                        r_voice_run <= n_voice_run_inc;
                        r_sil_run   <= (r_sil_run == 8'd0) ? 8'd0 : r_sil_run - 8'd1;
                        if (n_voice_run_inc >= minv) begin
                            if (r_adapt && (r_noise_frames > NOISE_GATE_N)) begin
                                if ({2'b00, r_energy} > noise3) begin
                                    r_voice_state <= 1'b1;
                                end
                            end else begin
                                r_voice_state <= 1'b1;
                            end
                        end
                    end else begin
                        r_sil_run   <= n_sil_run_inc;
                        r_voice_run <= (r_voice_run > 8'd2) ? r_voice_run - 8'd2 : 8'd0;
                        if (n_sil_run_inc >= hold) begin
                            r_voice_state <= 1'b0;
                        end
                    end
                    r_state <= ST_TRIM;
                end
                ST_TRIM: begin
                    // drop the oldest entries so the new bit fits under the cap
                    if (r_hist_len >= cap) begin
                        r_head     <= hist_wrap(r_head, trim_drop);
                        r_hist_len <= cap - LEN_W'(1);
                    end
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_hist_len <= r_hist_len + LEN_W'(1);
                    if (r_voice_state) begin
                        r_end_run <= 8'd0;
                        r_state   <= ST_FIN;
                    end else begin
                        r_end_run <= n_end_run_inc;
                        if (n_end_run_inc >= {2'b00, need}) begin
                            r_walk_idx <= '0;
                            r_total    <= '0;
                            r_recent   <= '0;
                            r_rd_valid <= 1'b0;
                            r_state    <= ST_WALK;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_WALK: begin
                    // read data arrives in the cycle after its address
                    if (r_rd_valid && !ram_rdata) begin
                        r_total <= r_total + LEN_W'(1);
                        if (r_rd_pos >= (r_hist_len >> 1)) begin
                            r_recent <= r_recent + LEN_W'(1);
                        end
                    end
                    r_rd_valid <= ram_re;
                    r_rd_pos   <= r_walk_idx;
                    if (ram_re) begin
                        r_walk_idx <= r_walk_idx + LEN_W'(1);
                    end else if (!r_rd_valid) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if ((32'(r_total) >= END_MIN_TOTAL) && (32'(r_recent) >= END_MIN_RECENT)) begin
                        r_end_pend <= 1'b1;
                    end else begin
                        r_end_run <= (r_end_run > 8'd2) ? r_end_run - 8'd2 : 8'd0;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_out_voice <= r_voice_state;
                        r_out_end   <= r_end_pend;
                        r_out_thr   <= r_energy_limit;
                        r_m_valid   <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // register writes arrive only while no frame is in work
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MIN_VOICE: r_min_voice <= i_cfg_data[7:0];
                    CFG_HOLD:      r_hold      <= i_cfg_data[7:0];
                    CFG_END_SIL:   r_end_sil   <= i_cfg_data[5:0];
                    CFG_ADAPT_EN: begin
                        if (i_cfg_data[0] && !r_adapt) begin
                            r_noise_mean   <= 16'd0;
                            r_noise_frames <= 16'd0;
                        end
                        r_adapt <= i_cfg_data[0];
                    end
                    CFG_THRESH: begin
                        r_energy_limit <= (i_cfg_data < THRESH_FLOOR) ? THRESH_FLOOR
                                                                      : i_cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_s_tready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tuser   = r_out_voice;
    assign o_m_tdata   = {{(M_TDATA_W - ENERGY_W - 1){1'b0}}, r_out_thr, r_out_end};

    `VHS_ASSERT(a_len_bound, i_clk, i_rst_n, r_hist_len <= LEN_W'(HISTORY_DEPTH), "history length beyond depth")
    `VHS_ASSERT(a_head_bound, i_clk, i_rst_n, 32'(r_head) < HISTORY_DEPTH, "history head out of range")
    `VHS_ASSERT(a_limit_floor, i_clk, i_rst_n, r_energy_limit >= THRESH_FLOOR, "energy limit under floor")
    `VHS_ASSERT_IMP(a_walk_recent, i_clk, i_rst_n, r_state == ST_WALK, r_recent <= r_total, "recent count exceeds total")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import vhs_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int HIST_DEPTH = 150;
    localparam int LIMIT      = 3_000_000;

    // indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

    typedef struct packed {
        logic        voice_active;
        logic        speech_end;
        logic [15:0] threshold;
    } t_verdict;

    typedef struct packed {
        logic        cand;
        logic [15:0] energy;
        logic        ack;
        logic        fixed;
        t_verdict    want;
    } t_probe;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    voice_hysteresis_segmenter #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // segmenter state as the block should hold it
    logic [7:0]  min_voice_p, hold_p;
    logic [5:0]  end_sil_p;
    logic        adapt_p;
    logic [7:0]  voice_run_p, silence_run_p, end_run_p;
    logic        voice_on_p, end_pending_p;
    logic [15:0] noise_mean_p, noise_n_p, limit_p;
    bit          quiet_hist[$];

    t_verdict verdict_q[$];
    int       mismatch_count = 0;
    int       beats_seen = 0;
    int       cycle_count = 0;
    bit       tx_idle_on, rx_idle_on;
    int       hold_requests = 0;
    int       holds_served = 0;
    int       rx_hold = 0;
    t_probe   probes[0:19];

    task automatic reset_segmenter();
        min_voice_p   = RST_MIN_VOICE;
        hold_p        = RST_HOLD;
        end_sil_p     = RST_END_SIL;
        adapt_p       = 1'b0;
        voice_run_p   = '0;
        silence_run_p = '0;
        end_run_p     = '0;
        voice_on_p    = 1'b0;
        end_pending_p = 1'b0;
        noise_mean_p  = '0;
        noise_n_p     = '0;
        limit_p       = RST_THRESH;
        quiet_hist.delete();
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIN_VOICE: min_voice_p = data[7:0];
            CFG_HOLD:      hold_p = data[7:0];
            CFG_END_SIL:   end_sil_p = data[5:0];
            CFG_ADAPT_EN: begin
                // only a 0 -> 1 switch restarts noise tracking
                if (data[0] && !adapt_p) begin
                    noise_mean_p = '0;
                    noise_n_p    = '0;
                end
                adapt_p = data[0];
            end
            CFG_THRESH:    limit_p = (data < THRESH_FLOOR) ? THRESH_FLOOR : data;
            default: ;
        endcase
    endtask

    task automatic segment_frame(input logic cand, input logic [15:0] e, input logic ack,
                                 output t_verdict r);
        logic [7:0]      minv, hold;
        int              need, cap, total, recent, i;
        longint unsigned sum, t;
        bit              quiet;
        minv = (min_voice_p == 8'd0) ? 8'd1 : min_voice_p;
        hold = (hold_p == 8'd0) ? 8'd1 : hold_p;
        need = (end_sil_p < END_SIL_MIN) ? int'(END_SIL_MIN) :
               (end_sil_p > END_SIL_MAX) ? int'(END_SIL_MAX) : int'(end_sil_p);

        if (ack && end_pending_p) begin
            end_pending_p = 1'b0;
            end_run_p     = '0;
            quiet_hist.delete();
        end

        if (adapt_p && e < limit_p) begin
            if (noise_n_p != 16'hFFFF) noise_n_p++;
            sum = 64'(noise_mean_p) * 64'(noise_n_p - 16'd1) + 64'(e);
            t = (sum + 64'(noise_n_p) / 2) / 64'(noise_n_p);
            noise_mean_p = (t > 64'd65535) ? 16'hFFFF : t[15:0];
            if (noise_n_p > NOISE_TRACK_N) begin
                t = 64'(noise_mean_p) * 2;
                if (t > 64'd65535) t = 64'd65535;
                limit_p = (t < 64'(THRESH_FLOOR)) ? THRESH_FLOOR : t[15:0];
            end
        end

        if (cand) begin
            if (voice_run_p != 8'hFF) voice_run_p++;
            if (silence_run_p != 8'd0) silence_run_p--;
            if (voice_run_p >= minv) begin
                // once enough noise is seen, a candidate also has to beat 3x the mean
                if (adapt_p && noise_n_p > NOISE_GATE_N) begin
                    if (64'(e) > 64'(noise_mean_p) * 3) voice_on_p = 1'b1;
                end else begin
                    voice_on_p = 1'b1;
                end
            end
        end else begin
            if (silence_run_p != 8'hFF) silence_run_p++;
            voice_run_p = (voice_run_p > 8'd2) ? voice_run_p - 8'd2 : 8'd0;
            if (silence_run_p >= hold) voice_on_p = 1'b0;
        end

        quiet = !voice_on_p;
        cap = need * 3;
        if (cap > HIST_DEPTH) cap = HIST_DEPTH;
        while (quiet_hist.size() >= cap && quiet_hist.size() > 0) quiet_hist.delete(0);
        quiet_hist.insert(quiet_hist.size(), quiet);
        if (!quiet) begin
            end_run_p = '0;
        end else begin
            if (end_run_p != 8'hFF) end_run_p++;
            if (int'(end_run_p) >= need) begin
                total  = 0;
                recent = 0;
                for (i = 0; i < quiet_hist.size(); i++) begin
                    if (!quiet_hist[i]) begin
                        total++;
                        if (i >= quiet_hist.size() / 2) recent++;
                    end
                end
                if (total >= END_MIN_TOTAL && recent >= END_MIN_RECENT) end_pending_p = 1'b1;
                else end_run_p = (end_run_p > 8'd2) ? end_run_p - 8'd2 : 8'd0;
            end
        end

        r.voice_active = voice_on_p;
        r.speech_end   = end_pending_p;
        r.threshold    = limit_p;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < 40)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     beats_seen, what, got, want);
        mismatch_count++;
    endtask

    // call at a falling edge; returns at a falling edge with valid still up
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        load_register(idx, data);
        @(negedge i_clk);
    endtask

    // unused upper data bits carry noise; the block must mask them
    task automatic set_regs(input logic [7:0] minv, input logic [7:0] hold,
                            input logic [5:0] end_sil, input logic adapt,
                            input logic [15:0] thr);
        write_reg(CFG_MIN_VOICE, {8'($urandom), minv});
        write_reg(CFG_HOLD, {8'($urandom), hold});
        write_reg(CFG_END_SIL, {10'($urandom), end_sil});
        write_reg(CFG_ADAPT_EN, {15'($urandom), adapt});
        write_reg(CFG_THRESH, thr);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic cand, input logic [15:0] e, input logic ack,
                              input logic fixed, input t_verdict fixed_want);
        t_verdict want;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cand;
        i_s_tdata  <= {7'd0, ack, e};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        segment_frame(cand, e, ack, want);
        verdict_q.insert(verdict_q.size(), fixed ? fixed_want : want);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every frame has come back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (verdict_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [15:0] loud_energy();
        int unsigned lo;
        lo = int'(noise_mean_p) * 3 + 1;
        if (lo > 65535 || $urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(65535, lo));
    endfunction

    function automatic logic [15:0] quiet_energy();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(int'(limit_p) - 1, 0));
    endfunction

    // talk spurts and pauses with random length and content, plus some noise
    task automatic drive_speech(input int n_items);
        int          left, len, kind, k;
        logic        cand, ack;
        logic [15:0] e;
        left = n_items;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            len = (kind < 4) ? $urandom_range(1, 30) :
                  (kind < 8) ? $urandom_range(1, 60) : $urandom_range(1, 8);
            if (len > left) len = left;
            for (k = 0; k < len; k++) begin
                if (kind < 4) begin
                    cand = ($urandom_range(0, 9) != 0);
                    e    = loud_energy();
                end else if (kind < 8) begin
                    cand = ($urandom_range(0, 9) == 0);
                    e    = quiet_energy();
                end else begin
                    cand = 1'($urandom);
                    e    = 16'($urandom);
                end
                ack = end_pending_p ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) == 0);
                send_frame(cand, e, ack, 1'b0, '0);
            end
            left -= len;
        end
    endtask

    // result sink with random stalls and one long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rx_hold    <= 700;
            i_m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_hold    <= $urandom_range(0, 11);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected beat, tdata", o_m_tdata, 0);
            end else begin
                want = verdict_q[0];
                verdict_q.delete(0);
                if (o_m_tuser !== want.voice_active)
                    report_mismatch("voice_active", o_m_tuser, want.voice_active);
                if (o_m_tdata[0] !== want.speech_end)
                    report_mismatch("speech_end", o_m_tdata[0], want.speech_end);
                if (o_m_tdata[16:1] !== want.threshold)
                    report_mismatch("adapted_threshold", o_m_tdata[16:1], want.threshold);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;

        // cand, energy, ack, typed-in, {voice_active, speech_end, threshold}
        probes = '{
            '{1'b0, 16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd655}},
            '{1'b0, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd655}},  // ack, nothing pending
            '{1'b1, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd655}},
            '{1'b1, 16'h5555, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd655}},
            '{1'b1, 16'hAAAA, 1'b1, 1'b1, '{1'b1, 1'b0, 16'd655}},  // third candidate
            '{1'b1, 16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'd655}},
            '{1'b0, 16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 16'd655}},  // hold keeps voice
            '{1'b1, 16'h0001, 1'b0, 1'b0, '0},
            '{1'b1, 16'h8000, 1'b0, 1'b0, '0},
            '{1'b1, 16'h7FFF, 1'b1, 1'b0, '0},
            '{1'b1, 16'd655,  1'b0, 1'b0, '0},
            '{1'b1, 16'd654,  1'b0, 1'b0, '0},
            '{1'b0, 16'd656,  1'b0, 1'b0, '0},
            '{1'b0, 16'h00FF, 1'b0, 1'b0, '0},
            '{1'b0, 16'hFF00, 1'b1, 1'b0, '0},
            '{1'b1, 16'h0F0F, 1'b0, 1'b0, '0},
            '{1'b0, 16'hF0F0, 1'b0, 1'b0, '0},
            '{1'b0, 16'd7,    1'b0, 1'b0, '0},
            '{1'b0, 16'd6,    1'b0, 1'b0, '0},
            '{1'b0, 16'd0,    1'b1, 1'b0, '0}
        };

        reset_segmenter();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < 20; k++)
            send_frame(probes[k].cand, probes[k].energy, probes[k].ack,
                       probes[k].fixed, probes[k].want);
        drive_speech(70);

        // shortest settings; threshold write below the floor
        settle();
        set_regs(8'd1, 8'd1, 6'd3, 1'b1, 16'h0000);
        drive_speech(100);

        // longest voice build-up, deepest history; saturate the counters
        settle();
        set_regs(8'd255, 8'd1, 6'd50, 1'b0, 16'hFFFF);
        for (k = 0; k < 270; k++) send_frame(1'b1, 16'($urandom), 1'b0, 1'b0, '0);
        // end goes pending and must stay until acknowledged
        for (k = 0; k < 280; k++) send_frame(1'b0, 16'($urandom), 1'b0, 1'b0, '0);
        drive_speech(40);

        // zero counts act as one, end silence below range; switch-on clears noise
        settle();
        set_regs(8'd0, 8'd0, 6'd0, 1'b1, 16'hAAAA);
        hold_requests++;
        drive_speech(120);

        // undecoded indexes, end silence above range, adaptive rewritten as 1
        settle();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
        write_reg(REG_SPARE_C, 16'h5A5A);
        set_regs(8'd2, 8'd5, 6'd63, 1'b1, 16'd6);
        drive_speech(70);
        settle();
        drive_speech(70);

        settle();
        set_regs(8'd4, 8'd255, 6'd20, 1'b1, 16'd3000);
        drive_speech(130);

        settle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_regs(8'd3, 8'd8, 6'd12, 1'b0, 16'h5555);
        drive_speech(130);

        i_s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ voice_hysteresis_segmenter.f @@
+incdir+design
design/vhs_pkg.sv
design/vhs_ram.sv
design/voice_hysteresis_segmenter.sv
tb/sv/testbench.sv
